// File: hdl/dip_pkg.sv
// Shared types and constants for the DER integer sequence parser.
// No dependencies; used by dip_core and der_integer_sequence_parser.
package dip_pkg;

  // Width of the kept value: upper bytes of a longer field shift out.
  localparam int ValueWidth = 64;
  localparam int OutWidth   = 64;

  // Configuration register indexes.
  localparam logic RegHeaderBytes = 1'b0;
  localparam logic RegFieldCount  = 1'b1;

  localparam logic [7:0] HeaderBytesReset = 8'd2;
  localparam logic [3:0] FieldCountReset  = 4'd9;

  // One completed field, passed from the parser core to the output stage.
  typedef struct packed {
    logic                  valid;
    logic [3:0]            index;
    logic [ValueWidth-1:0] value;
    logic                  last;
  } result_t;

endpackage

// File: hdl/dip_core.sv
// Parser state and per-byte next-state logic for the DER integer parser.
// Depends on dip_pkg (result_t, ValueWidth).
module dip_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             start_of_key,
  input  logic [7:0]       header_bytes,
  input  logic [3:0]       field_count,
  output dip_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SKIP,
    PH_TAG,
    PH_LEN,
    PH_VALUE,
    PH_DONE
  } phase_t;

  phase_t                         phase;
  phase_t                         phase_next;
  phase_t                         phase_eff;
  logic [7:0]                     skip_left;
  logic [7:0]                     skip_next;
  logic [7:0]                     skip_eff;
  logic [7:0]                     bytes_left;
  logic [7:0]                     bytes_next;
  logic [7:0]                     bytes_eff;
  logic [dip_pkg::ValueWidth-1:0] accumulator;
  logic [dip_pkg::ValueWidth-1:0] accumulator_next;
  logic [dip_pkg::ValueWidth-1:0] acc_eff;
  logic [dip_pkg::ValueWidth+7:0] acc_shift;
  logic [3:0]                     field_number;
  logic [3:0]                     field_number_next;
  logic [3:0]                     fn_eff;
  logic [3:0]                     fn_inc;
  logic [3:0]                     count_eff;
  logic                           finish;
  logic                           is_last;

  // A start byte restarts the parse and is then consumed like any other byte.
  always_comb begin
    if (start_of_key) begin
      phase_eff = (header_bytes != 8'd0) ? PH_SKIP : PH_TAG;
      skip_eff  = header_bytes;
      bytes_eff = 8'd0;
      acc_eff   = '0;
      fn_eff    = 4'd0;
    end else begin
      phase_eff = phase;
      skip_eff  = skip_left;
      bytes_eff = bytes_left;
      acc_eff   = accumulator;
      fn_eff    = field_number;
    end
  end

  assign acc_shift = {acc_eff, data_byte};
  assign fn_inc    = fn_eff + 4'd1;
  assign count_eff = (field_count == 4'd0) ? 4'd1 : field_count;
  assign is_last   = (fn_inc == count_eff);

  always_comb begin
    phase_next        = phase_eff;
    skip_next         = skip_eff;
    bytes_next        = bytes_eff;
    accumulator_next  = acc_eff;
    field_number_next = fn_eff;
    finish            = 1'b0;
    case (phase_eff)
      PH_SKIP: begin
        skip_next = skip_eff - 8'd1;
        if (skip_eff == 8'd1) begin
          phase_next = PH_TAG;
        end
      end
      PH_TAG: begin
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        accumulator_next = '0;
        bytes_next       = data_byte;
        if (data_byte == 8'd0) begin
          finish = 1'b1;
        end else begin
          phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        accumulator_next = acc_shift[dip_pkg::ValueWidth-1:0];
        bytes_next       = bytes_eff - 8'd1;
        if (bytes_eff == 8'd1) begin
          finish = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (finish) begin
      field_number_next = fn_inc;
      phase_next        = is_last ? PH_DONE : PH_TAG;
    end
  end

  assign res.valid = finish;
  assign res.index = fn_eff;
  assign res.value = accumulator_next;
  assign res.last  = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      skip_left    <= 8'd0;
      bytes_left   <= 8'd0;
      accumulator  <= '0;
      field_number <= 4'd0;
    end else if (step) begin
      phase        <= phase_next;
      skip_left    <= skip_next;
      bytes_left   <= bytes_next;
      accumulator  <= accumulator_next;
      field_number <= field_number_next;
    end
  end

endmodule

// File: hdl/der_integer_sequence_parser.sv
// Top level of the DER integer sequence parser: config registers, handshake
// and result register. Depends on dip_pkg and dip_core.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one key byte per transaction,
//   with start_of_key set on the first byte of each blob. After header_bytes
//   skipped bytes the block walks tag/length/value integer fields and emits
//   one result transaction (out_valid/out_ready) per completed field, with
//   its index, its low 64 value bits and a flag on the last configured field.
//   Bytes after the last field are dropped until the next start.
//   A result appears in the cycle after the byte that completes it.
//   Throughput: one byte per cycle unless stalled; the result register is the only stage.
//   in_ready is low only while a result is held and out_ready is low, so a
//   stalled receiver stalls the input after at most one pending result.
//   Reset: header_bytes returns to 2, field_count to 9, the parser waits
//   for a start byte and no result is pending.
//   Configuration: write_enable/reg_index/write_data, index 0 header_bytes,
//   index 1 field_count; write only while the block is idle.
module der_integer_sequence_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic        reg_index,
  input  logic [7:0]  write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_of_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  field_index,
  output logic [63:0] field_value,
  output logic        last_field
);

  logic [7:0]       header_bytes;
  logic [3:0]       field_count;
  logic             in_fire;
  dip_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= dip_pkg::HeaderBytesReset;
      field_count  <= dip_pkg::FieldCountReset;
    end else if (write_enable) begin
      case (reg_index)
        dip_pkg::RegHeaderBytes: header_bytes <= write_data;
        dip_pkg::RegFieldCount:  field_count  <= write_data[3:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  dip_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (in_fire),
    .data_byte    (data_byte),
    .start_of_key (start_of_key),
    .header_bytes (header_bytes),
    .field_count  (field_count),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result register only when a field completes.
  always_ff @(posedge clk) begin
    if (in_fire && res.valid) begin
      field_index <= res.index;
      field_value <= dip_pkg::OutWidth'(res.value);
      last_field  <= res.last;
    end
  end

endmodule

// File: hdl/dip_checker.sv
// Port-level checks for der_integer_sequence_parser, bound to the top level.
// No package dependencies.
module dip_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        start_of_key,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  field_index,
  input logic [63:0] field_value,
  input logic        last_field
);

  // Hold a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(field_index) &&
      $stable(field_value) && $stable(last_field))
    else $error("stalled result changed or dropped");

  // A new result needs an accepted byte in the cycle before.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without an accepted byte");

  // A start byte is a header or tag byte and never completes a field.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && start_of_key && out_ready |=> !out_valid)
    else $error("start byte produced a result");

  // Drop any pending result on reset.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind der_integer_sequence_parser dip_checker u_dip_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .start_of_key (start_of_key),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .field_index  (field_index),
  .field_value  (field_value),
  .last_field   (last_field)
);
